// ===== hw/rtl/ddo_pkg.sv =====
package ddo_pkg;

    // CORDIC iteration count and arctangent table depth
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int COR_ITERS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int CNT_W        = $clog2(ATAN_ENTRIES);

    // datapath widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int COR_W  = 34;
    localparam int POS_W  = 24;
    localparam int ACC_W  = 73;

    // fixed constants
    localparam logic [MUL_W-1:0] TURN_PER_RAD_Q32 = 33'd683565276;
    localparam logic [COR_W-1:0] CORDIC_GAIN_Q30  = 34'd652032874;
    localparam logic [15:0]      MPP_RESET        = 16'd8454;
    localparam logic [15:0]      IVWB_RESET       = 16'd1237;

    // configuration register indexes
    localparam logic REG_MPP  = 1'b0;
    localparam logic REG_IVWB = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
        S_COR, S_M9, S_M10, S_M11, S_M12, S_M13, S_DONE
    } t_state;

    typedef struct packed {
        logic [15:0] mpp;
        logic [15:0] ivwb;
    } t_cfg;

    typedef struct packed {
        logic        load;
        logic        step;
        logic [31:0] ang;
    } t_cor_ctrl;

    typedef struct packed {
        logic                    last;
        logic signed [MUL_W-1:0] c;
        logic signed [MUL_W-1:0] s;
    } t_cor_stat;

    // arctangent of 2^-i in Q32 turns
    function automatic logic [31:0] atan_q32(input logic [CNT_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // position plus rounded step, saturated to the coordinate range
    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] pos,
                                                 input logic [42:0] delta);
        logic signed [43:0] sum;
        logic [POS_W-1:0]   res;
        sum = $signed({{20{pos[POS_W-1]}}, pos}) + $signed({delta[42], delta});
        if (sum > 44'sd8388607) begin
            res = 24'h7FFFFF;
        end else if (sum < -44'sd8388608) begin
            res = 24'h800000;
        end else begin
            res = sum[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/diff_drive_odometry.sv =====
// Channel  Direction  Handshake                    Payload
// input    in         i_in_valid / o_in_stall      i_action, i_right_steps, i_left_steps,
//                                                  i_set_x, i_set_y, i_set_heading
// result   out        o_out_valid / i_out_stall    o_pose_x, o_pose_y, o_pose_heading
// config   in         APB psel/penable/pwrite      mpp at 0x0, inverse wheel base at 0x4
//
// A set-pose transaction offers its result in the cycle after acceptance; an update runs
// the shared multiplier sequence and the one-rotation-per-cycle CORDIC. One transaction is
// in flight at a time: o_in_stall stays high from acceptance until the result has been
// taken. Synchronous active-low reset clears pose, last counts and state, and loads the
// config registers with their reset values. The result holds while i_out_stall is high.
module diff_drive_odometry
    import ddo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [31:0] i_right_steps,
    input  logic [31:0] i_left_steps,
    input  logic [23:0] i_set_x,
    input  logic [23:0] i_set_y,
    input  logic [15:0] i_set_heading,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [23:0] o_pose_x,
    output logic [23:0] o_pose_y,
    output logic [15:0] o_pose_heading,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state                   r_state, n_state;
    t_cfg                     w_cfg;
    t_cor_ctrl                w_cor_ctrl;
    t_cor_stat                w_cor_stat;
    logic signed [MUL_W-1:0]  w_a, w_b;
    logic signed [PROD_W-1:0] w_prod;
    logic                     w_accept;

    logic [31:0]      r_last_r, r_last_l, r_dcr, r_dcl;
    logic [POS_W-1:0] r_pos_x, r_pos_y;
    logic [15:0]      r_heading;
    logic [47:0]      r_dr;
    logic [40:0]      r_dist;
    logic [41:0]      r_diff;
    logic [57:0]      r_rad;
    logic [ACC_W-1:0] r_acc;

    logic [49:0]      w_sum, w_dsub;
    logic [56:0]      w_tl;
    logic [32:0]      w_turns;
    logic [31:0]      w_h32, w_mid, w_nh;
    logic [ACC_W-1:0] w_full;

    ddo_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ddo_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    ddo_cordic u_cordic (
        .i_clk  (i_clk),
        .i_ctrl (w_cor_ctrl),
        .o_stat (w_cor_stat)
    );

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: next state, multiplier operands, CORDIC control
    always_comb begin
        n_state         = r_state;
        w_a             = '0;
        w_b             = '0;
        w_cor_ctrl.load = 1'b0;
        w_cor_ctrl.step = 1'b0;
        w_cor_ctrl.ang  = w_mid;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = i_action ? S_DONE : S_M0;
            end
            S_M0: begin
                w_a = {r_dcr[31], r_dcr};
                w_b = {17'h0, w_cfg.mpp};
                n_state = S_M1;
            end
            S_M1: begin
                w_a = {r_dcl[31], r_dcl};
                w_b = {17'h0, w_cfg.mpp};
                n_state = S_M2;
            end
            S_M2: n_state = S_M3;
            S_M3: begin
                w_a = {{12{r_diff[41]}}, r_diff[41:21]};
                w_b = {17'h0, w_cfg.ivwb};
                n_state = S_M4;
            end
            S_M4: begin
                w_a = {12'h0, r_diff[20:0]};
                w_b = {17'h0, w_cfg.ivwb};
                n_state = S_M5;
            end
            S_M5: n_state = S_M6;
            S_M6: begin
                w_a = r_rad[56:24];
                w_b = TURN_PER_RAD_Q32;
                n_state = S_M7;
            end
            S_M7: begin
                w_a = {9'h0, r_rad[23:0]};
                w_b = TURN_PER_RAD_Q32;
                n_state = S_M8;
            end
            S_M8: begin
                w_cor_ctrl.load = 1'b1;
                n_state = S_COR;
            end
            S_COR: begin
                w_cor_ctrl.step = 1'b1;
                if (w_cor_stat.last) n_state = S_M9;
            end
            S_M9: begin
                w_a = {{7{r_dist[40]}}, r_dist[40:15]};
                w_b = w_cor_stat.c;
                n_state = S_M10;
            end
            S_M10: begin
                w_a = {18'h0, r_dist[14:0]};
                w_b = w_cor_stat.c;
                n_state = S_M11;
            end
            S_M11: begin
                w_a = {{7{r_dist[40]}}, r_dist[40:15]};
                w_b = w_cor_stat.s;
                n_state = S_M12;
            end
            S_M12: begin
                w_a = {18'h0, r_dist[14:0]};
                w_b = w_cor_stat.s;
                n_state = S_M13;
            end
            S_M13: n_state = S_DONE;
            S_DONE: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // wheel travel sum and difference, rounded to Q8 mm
    assign w_sum  = {{2{r_dr[47]}}, r_dr} + {{2{w_prod[47]}}, w_prod[47:0]} + 50'd256;
    assign w_dsub = {{2{r_dr[47]}}, r_dr} - {{2{w_prod[47]}}, w_prod[47:0]} + 50'd128;

    // rotation to turns modulo 2^33, midpoint and new heading
    assign w_tl    = w_prod[56:0] + 57'd8388608;
    assign w_turns = r_acc[32:0] + w_tl[56:24];
    assign w_h32   = {r_heading, 16'h0};
    assign w_mid   = w_h32 + w_turns[32:1];
    assign w_nh    = w_h32 + w_turns[31:0];

    // distance times cos or sin, rounded from Q30
    assign w_full = r_acc + {{7{w_prod[PROD_W-1]}}, w_prod} + 73'd536870912;

    // pose and count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_r  <= '0;
            r_last_l  <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
        end else begin
            if (w_accept && i_action) begin
                r_pos_x   <= i_set_x;
                r_pos_y   <= i_set_y;
                r_heading <= i_set_heading;
            end else if (w_accept) begin
                r_last_r <= i_right_steps;
                r_last_l <= i_left_steps;
            end
            if (r_state == S_M8) r_heading <= w_nh[31:16] + {15'h0, w_nh[15]};
            if (r_state == S_M11) r_pos_x <= sat_add(r_pos_x, w_full[72:30]);
            if (r_state == S_M13) r_pos_y <= sat_add(r_pos_y, w_full[72:30]);
        end
    end

    // datapath scratch registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dcr <= i_right_steps - r_last_r;
            r_dcl <= i_left_steps - r_last_l;
        end
        unique case (r_state)
            S_M1:  r_dr <= w_prod[47:0];
            S_M2: begin
                r_dist <= w_sum[49:9];
                r_diff <= w_dsub[49:8];
            end
            S_M4:  r_acc <= {w_prod[51:0], 21'h0};
            S_M5:  r_rad <= r_acc[57:0] + w_prod[57:0];
            S_M7:  r_acc <= {40'h0, w_prod[32:0]};
            S_M10: r_acc <= {w_prod[57:0], 15'h0};
            S_M12: r_acc <= {w_prod[57:0], 15'h0};
            default: ;
        endcase
    end

    assign o_pose_x       = r_pos_x;
    assign o_pose_y       = r_pos_y;
    assign o_pose_heading = r_heading;

    // set pose goes straight to the result with the new pose
    a_set_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action) |=> (o_out_valid && o_pose_x == $past(i_set_x)))
        else $error("set pose not presented");

    // an update latches the counts it was given
    a_last_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_action) |=> (r_last_r == $past(i_right_steps)
                                    && r_last_l == $past(i_left_steps)))
        else $error("last counts not captured");

    // a result is only offered while new transactions are held off
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result offered while input open");

    // y position and heading do not move while a result waits
    a_pose_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_pose_y) && $stable(o_pose_heading))
        else $error("pose changed under stall");

endmodule

// ===== hw/rtl/ddo_mul.sv =====
module ddo_mul
    import ddo_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // shared signed multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/ddo_cordic.sv =====
module ddo_cordic
    import ddo_pkg::*;
(
    input  logic      i_clk,
    input  t_cor_ctrl i_ctrl,
    output t_cor_stat o_stat
);

    logic signed [COR_W-1:0] r_x, r_y, r_z;
    logic                    r_flip;
    logic [CNT_W-1:0]        r_cnt;
    logic [31:0]             w_fold;
    logic signed [COR_W-1:0] w_dx, w_dy, w_atan, w_cx, w_sy;

    // fold the second and third quarter onto the other half
    always_comb begin
        w_fold = i_ctrl.ang;
        if (i_ctrl.ang[31:30] == 2'b01 || i_ctrl.ang[31:30] == 2'b10) begin
            w_fold = {~i_ctrl.ang[31], i_ctrl.ang[30:0]};
        end
    end

    assign w_dx   = r_y >>> r_cnt;
    assign w_dy   = r_x >>> r_cnt;
    assign w_atan = $signed({2'b00, atan_q32(r_cnt)});

    // one rotation per cycle while step is asserted
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x    <= CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= $signed({{2{w_fold[31]}}, w_fold});
            r_flip <= (i_ctrl.ang[31:30] == 2'b01 || i_ctrl.ang[31:30] == 2'b10);
            r_cnt  <= '0;
        end else if (i_ctrl.step) begin
            if (!r_z[COR_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign w_cx = r_flip ? -r_x : r_x;
    assign w_sy = r_flip ? -r_y : r_y;

    assign o_stat.last = (r_cnt == CNT_W'(COR_ITERS - 1));
    assign o_stat.c    = w_cx[MUL_W-1:0];
    assign o_stat.s    = w_sy[MUL_W-1:0];

endmodule

// ===== hw/rtl/ddo_apb.sv =====
module ddo_apb
    import ddo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [15:0] r_mpp, r_ivwb;

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpp  <= MPP_RESET;
            r_ivwb <= IVWB_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_MPP:  r_mpp  <= pwdata[15:0];
                REG_IVWB: r_ivwb <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            REG_MPP:  prdata = {16'h0, r_mpp};
            REG_IVWB: prdata = {16'h0, r_ivwb};
            default:  prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign o_cfg.mpp  = r_mpp;
    assign o_cfg.ivwb = r_ivwb;

endmodule
